FILE: hdl/rms3_pkg.sv
// Shared types and constants of the 3x3 RMS shade filter.
`default_nettype none
package rms3_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

  localparam int COORD_W = 8;
  localparam int SHADE_W = 8;
  localparam int GLOW_W  = 6;
  localparam int DIM_W   = 9;
  localparam int CFG_IDX_W = 2;

  localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Neighbor coordinates carry two spare bits so that a step left of column
  // zero wraps to a value far above any frame size.
  localparam int NB_W = $clog2(MAX_DIM + 1) + 2;

  localparam int SQ_W     = 2 * SHADE_W;
  localparam int SUM_W    = $clog2(9 * 255 * 255 + 1);
  localparam int CNT_W    = $clog2(10);
  localparam int UNIT_W   = SQ_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SHADE_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [SQ_W-1:0]  SQRT_START = SQ_W'(1) << (2 * (SHADE_W - 1));
  localparam logic [DIM_W-1:0] DIM_RESET  = DIM_W'(256);
  localparam logic [SHADE_W-1:0] SHADE_FULL = SHADE_W'(255);
  localparam int GLOW_SHIFT = 2;

  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DIV,
    S_SQRT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [UNIT_W-1:0] a;
    logic [UNIT_W-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [UNIT_W-1:0] diff;
    logic              ge;
  } sub_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/rms3_frame_mem.sv
// Single-port frame store of shade samples with registered read data.
`default_nettype none
module rms3_frame_mem
  import rms3_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [ADDR_W-1:0]  addr,
  input  wire logic [SHADE_W-1:0] wdata,
  output logic      [SHADE_W-1:0] rdata
);

  logic [SHADE_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hdl/rms3_sub_unit.sv
// Shared subtract and compare unit used by the divider and square root steps.
`default_nettype none
module rms3_sub_unit
  import rms3_pkg::*;
(
  input  wire sub_req_t req,
  output sub_rsp_t      rsp
);

  logic [UNIT_W:0] wide;

  always_comb begin
    wide     = {1'b0, req.a} - {1'b0, req.b};
    rsp.diff = wide[UNIT_W-1:0];
    rsp.ge   = ~wide[UNIT_W];
  end

endmodule
`default_nettype wire

FILE: hdl/rms3_shade_top.sv
// Glow channel of a result word, computed from its shade value.
`default_nettype none
module rms3_glow_calc
  import rms3_pkg::*;
(
  input  wire logic [SHADE_W-1:0] shade,
  output logic      [GLOW_W-1:0]  glow
);

  logic [SHADE_W-1:0] inv;

  always_comb begin
    inv  = SHADE_FULL - shade;
    glow = GLOW_W'(inv >> GLOW_SHIFT);
  end

endmodule
`default_nettype wire

FILE: hdl/rms_3x3_shade_filter.sv
// Top level of the 3x3 RMS shade filter: control sequencer, datapath and ports.
// A store word inside the frame writes the frame store as it is taken. A query
// word inside the frame holds off the next word until it is through: nine
// neighbor reads through the single frame store port, an add of the last square,
// 20 restoring division steps and 8 square root steps on the one shared subtract
// unit, and a load of the result word when the output is free. A query outside
// the frame goes straight to the result load. The result sits in an output
// register, so the block accepts the next word while a result waits. The frame
// store is not cleared; a query must only cover positions that were stored.
`default_nettype none
module rms_3x3_shade_filter
  import rms3_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 func,
  input  wire logic [COORD_W-1:0]   col,
  input  wire logic [COORD_W-1:0]   row,
  input  wire logic [SHADE_W-1:0]   sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [SHADE_W-1:0]   shade,
  output logic      [GLOW_W-1:0]    glow,
  output logic                      bad_coord,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  state_t state, state_next;

  logic [DIM_W-1:0]   frame_width, frame_height;
  logic [NB_W-1:0]    w_eff, h_eff;
  logic               in_accept, in_frame;
  logic [ADDR_W-1:0]  wr_addr, nb_addr, mem_addr;
  logic               mem_we;
  logic [SHADE_W-1:0] rdata;

  logic [COORD_W-1:0] q_col, q_row;
  logic               q_bad;
  logic [1:0]         dx, dy;
  logic [NB_W-1:0]    nr, nc;
  logic               nb_ok, last_nb, rd_pend;
  logic [SQ_W-1:0]    sq;
  logic [SUM_W-1:0]   acc;
  logic [CNT_W-1:0]   cnt, rem;
  logic [CNT_W:0]     div_t;
  logic [STEP_W-1:0]  step;
  logic [SQ_W-1:0]    root, sbit;
  logic               out_load;
  logic [GLOW_W-1:0]  glow_calc;

  sub_req_t sub_req;
  sub_rsp_t sub_rsp;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_RESET;
      frame_height <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      w_eff = NB_W'(1);
    end else if (NB_W'(frame_width) > NB_W'(MAX_WIDTH)) begin
      w_eff = NB_W'(MAX_WIDTH);
    end else begin
      w_eff = NB_W'(frame_width);
    end
    if (frame_height == '0) begin
      h_eff = NB_W'(1);
    end else if (NB_W'(frame_height) > NB_W'(MAX_HEIGHT)) begin
      h_eff = NB_W'(MAX_HEIGHT);
    end else begin
      h_eff = NB_W'(frame_height);
    end
  end

  always_comb begin
    in_frame = (NB_W'(col) < w_eff) && (NB_W'(row) < h_eff);
    wr_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col);
    nr      = NB_W'(q_row) + NB_W'(dy) - NB_W'(1);
    nc      = NB_W'(q_col) + NB_W'(dx) - NB_W'(1);
    nb_ok   = (nr < h_eff) && (nc < w_eff);
    nb_addr = ADDR_W'(ADDR_W'(nr) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(nc);
    last_nb = (dy == 2'd2) && (dx == 2'd2);
    mem_we  = in_accept && (func == FUNC_STORE) && in_frame;
    mem_addr = (state == S_IDLE) ? wr_addr : nb_addr;
    sq      = SQ_W'(rdata) * SQ_W'(rdata);
    div_t   = {rem, acc[SUM_W-1]};
  end

  rms3_frame_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (sample),
    .rdata (rdata)
  );

  always_comb begin
    if (state == S_SQRT) begin
      sub_req.a = UNIT_W'(acc[SQ_W-1:0]);
      sub_req.b = UNIT_W'(root) + UNIT_W'(sbit);
    end else begin
      sub_req.a = UNIT_W'(div_t);
      sub_req.b = UNIT_W'(cnt);
    end
  end

  rms3_sub_unit u_sub (
    .req (sub_req),
    .rsp (sub_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (func == FUNC_QUERY)) begin
          state_next = in_frame ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        if (last_nb) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DIV;
      S_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      dx      <= '0;
      dy      <= '0;
      cnt     <= '0;
      rem     <= '0;
      step    <= '0;
      q_bad   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept && (func == FUNC_QUERY)) begin
            q_col   <= col;
            q_row   <= row;
            q_bad   <= !in_frame;
            dx      <= '0;
            dy      <= '0;
            acc     <= '0;
            cnt     <= '0;
            rd_pend <= 1'b0;
          end
        end
        S_READ: begin
          rd_pend <= nb_ok;
          if (dx == 2'd2) begin
            dx <= '0;
            dy <= dy + 2'd1;
          end else begin
            dx <= dx + 2'd1;
          end
          if (rd_pend) begin
            acc <= acc + SUM_W'(sq);
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          rd_pend <= 1'b0;
          if (rd_pend) begin
            acc <= acc + SUM_W'(sq);
            cnt <= cnt + CNT_W'(1);
          end
          rem  <= '0;
          step <= '0;
        end
        S_DIV: begin
          if (sub_rsp.ge) begin
            rem <= sub_rsp.diff[CNT_W-1:0];
            acc <= {acc[SUM_W-2:0], 1'b1};
          end else begin
            rem <= div_t[CNT_W-1:0];
            acc <= {acc[SUM_W-2:0], 1'b0};
          end
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step <= '0;
            root <= '0;
            sbit <= SQRT_START;
          end else begin
            step <= step + STEP_W'(1);
          end
        end
        S_SQRT: begin
          if (sub_rsp.ge) begin
            acc  <= SUM_W'(sub_rsp.diff[SQ_W-1:0]);
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
          step <= step + STEP_W'(1);
        end
        default: ;
      endcase
    end
  end

  rms3_glow_calc u_glow (
    .shade (root[SHADE_W-1:0]),
    .glow  (glow_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      shade     <= q_bad ? '0 : root[SHADE_W-1:0];
      glow      <= q_bad ? '0 : glow_calc;
      bad_coord <= q_bad;
    end
  end

`ifndef SYNTHESIS
  a_div_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt != '0))
    else $error("divider running with zero sample count");

  a_rem_below_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < cnt))
    else $error("division remainder not below sample count");

  a_root_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !q_bad) |-> (root[SQ_W-1:SHADE_W] == '0))
    else $error("square root wider than a shade value");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result word loaded outside the done state");
`endif

endmodule
`default_nettype wire
